### src/rgba8_alpha_over_blend_defines.svh
// ----------------------------------------------------------------------------
// rgba8_alpha_over_blend_defines : assertion macros
// shared property wrappers for the compositor checker
// ----------------------------------------------------------------------------
`ifndef RGBA8_ALPHA_OVER_BLEND_DEFINES_SVH
`define RGBA8_ALPHA_OVER_BLEND_DEFINES_SVH

// property checked only while out of reset
`define RGBAOB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also covers the reset cycles
`define RGBAOB_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/rgbaob_pkg.sv
// ----------------------------------------------------------------------------
// rgbaob_pkg : shared types and constants
// widths, pixel structs and divider cell state for the over compositor
// ----------------------------------------------------------------------------
package rgbaob_pkg;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned W16       = 16;
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned PROD_W    = CH_W + W16;
    localparam int unsigned IN_W      = 8 * CH_W;
    localparam int unsigned OUT_W     = 4 * CH_W;

    localparam logic [W16-1:0]    FULL16 = 16'hFFFF;
    localparam logic [PROD_W-1:0] HALF16 = 24'h008000;
    localparam logic [16:0]       HALF8  = 17'd128;

    // one input pixel pair
    typedef struct packed {
        logic [CH_W-1:0] over_alpha;
        logic [CH_W-1:0] over_blue;
        logic [CH_W-1:0] over_green;
        logic [CH_W-1:0] over_red;
        logic [CH_W-1:0] base_alpha;
        logic [CH_W-1:0] base_blue;
        logic [CH_W-1:0] base_green;
        logic [CH_W-1:0] base_red;
    } t_pixel;

    // one result pixel
    typedef struct packed {
        logic [CH_W-1:0] out_alpha;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_red;
    } t_result;

    // colour channels carried alongside the divider
    typedef struct packed {
        logic [CH_W-1:0] base_red;
        logic [CH_W-1:0] base_green;
        logic [CH_W-1:0] base_blue;
        logic [CH_W-1:0] over_red;
        logic [CH_W-1:0] over_green;
        logic [CH_W-1:0] over_blue;
    } t_color;

    // side data that rides along the cell chain
    typedef struct packed {
        t_color          color;
        logic [CH_W-1:0] alpha;
        logic            zero;
    } t_side;

    // partial remainder, shifting dividend/quotient and divisor of one cell
    typedef struct packed {
        logic [W16-1:0] rem;
        logic [W16-1:0] shift;
        logic [W16-1:0] divisor;
    } t_div;

endpackage

### src/rgbaob_prep.sv
// ----------------------------------------------------------------------------
// rgbaob_prep : weight and alpha front end
// two stages: weights, then the rounded dividend and the output alpha
// ----------------------------------------------------------------------------
module rgbaob_prep (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ce,
    input  logic                  i_valid,
    input  rgbaob_pkg::t_pixel    i_pix,
    output logic                  o_valid,
    output rgbaob_pkg::t_div      o_div,
    output rgbaob_pkg::t_side     o_side
);

    logic                  r1_valid;
    logic [15:0]           r1_wb;
    logic [15:0]           r1_sum;
    logic [15:0]           r1_ap;
    logic [7:0]            r1_base_alpha;
    rgbaob_pkg::t_color    r1_color;

    logic [15:0]           n1_wb;
    logic [15:0]           n1_wo;
    logic [15:0]           n1_ap;
    rgbaob_pkg::t_color    n1_color;

    logic                  r2_valid;
    rgbaob_pkg::t_div      r2_div;
    rgbaob_pkg::t_side     r2_side;

    logic [31:0]           n2_num;
    logic [16:0]           n2_ax;
    logic [16:0]           n2_aq;
    rgbaob_pkg::t_div      n2_div;
    rgbaob_pkg::t_side     n2_side;

    // stage 1: base weight, overlay weight and the alpha product
    always_comb begin
        n1_wb = {8'h00, ~i_pix.over_alpha} * {8'h00, i_pix.base_alpha};
        n1_wo = {i_pix.over_alpha, 8'h00} - {8'h00, i_pix.over_alpha};
        n1_ap = {8'h00, i_pix.over_alpha} * {8'h00, ~i_pix.base_alpha};
        n1_color.base_red   = i_pix.base_red;
        n1_color.base_green = i_pix.base_green;
        n1_color.base_blue  = i_pix.base_blue;
        n1_color.over_red   = i_pix.over_red;
        n1_color.over_green = i_pix.over_green;
        n1_color.over_blue  = i_pix.over_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_ce) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_wb         <= n1_wb;
            r1_sum        <= n1_wb + n1_wo;
            r1_ap         <= n1_ap;
            r1_base_alpha <= i_pix.base_alpha;
            r1_color      <= n1_color;
        end
    end

    // stage 2: dividend wb*65535 + sum/2, alpha divided by 255
    always_comb begin
        n2_num = {r1_wb, 16'h0000} + {17'd0, r1_sum[15:1]} - {16'h0000, r1_wb};
        n2_ax  = {1'b0, r1_ap} + rgbaob_pkg::HALF8;
        // x/255 as (x + 1 + x/256) / 256, exact over this range
        n2_aq  = n2_ax + 17'd1 + (n2_ax >> 8);
        n2_div.rem     = n2_num[31:16];
        n2_div.shift   = n2_num[15:0];
        n2_div.divisor = r1_sum;
        n2_side.color  = r1_color;
        n2_side.alpha  = r1_base_alpha + n2_aq[15:8];
        n2_side.zero   = (r1_sum == 16'h0000);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_ce) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r2_div  <= n2_div;
            r2_side <= n2_side;
        end
    end

    assign o_valid = r2_valid;
    assign o_div   = r2_div;
    assign o_side  = r2_side;

endmodule

### src/rgbaob_div_cell.sv
// ----------------------------------------------------------------------------
// rgbaob_div_cell : one restoring division step
// shifts in one dividend bit, compares and subtracts, emits one quotient bit
// ----------------------------------------------------------------------------
module rgbaob_div_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ce,
    input  logic                  i_valid,
    input  rgbaob_pkg::t_div      i_div,
    input  rgbaob_pkg::t_side     i_side,
    output logic                  o_valid,
    output rgbaob_pkg::t_div      o_div,
    output rgbaob_pkg::t_side     o_side
);

    logic                  r_valid;
    rgbaob_pkg::t_div      r_div;
    rgbaob_pkg::t_side     r_side;

    logic [16:0]           n_trial;
    logic [16:0]           n_diff;
    logic                  n_ge;
    rgbaob_pkg::t_div      n_div;

    // compare and subtract against the divisor
    always_comb begin
        n_trial       = {i_div.rem, i_div.shift[15]};
        n_diff        = n_trial - {1'b0, i_div.divisor};
        n_ge          = (n_trial >= {1'b0, i_div.divisor});
        n_div.rem     = n_ge ? n_diff[15:0] : n_trial[15:0];
        n_div.shift   = {i_div.shift[14:0], n_ge};
        n_div.divisor = i_div.divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_div  <= n_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

### src/rgbaob_mix.sv
// ----------------------------------------------------------------------------
// rgbaob_mix : colour weighting
// registered channel products, then rounded sum and zero-weight override
// ----------------------------------------------------------------------------
module rgbaob_mix (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ce,
    input  logic                  i_valid,
    input  logic [15:0]           i_nb,
    input  rgbaob_pkg::t_side     i_side,
    output logic                  o_valid,
    output rgbaob_pkg::t_result   o_result
);

    localparam int unsigned PW = rgbaob_pkg::PROD_W;

    logic                  r_valid;
    logic [PW-1:0]         r_pb [3];
    logic [PW-1:0]         r_po [3];
    logic                  r_zero;
    logic [7:0]            r_alpha;

    logic [15:0]           n_no;
    logic [7:0]            n_bc [3];
    logic [7:0]            n_oc [3];
    logic [PW-1:0]         n_sum [3];
    logic [7:0]            n_ch [3];

    // channel selection and overlay weight
    always_comb begin
        n_no    = rgbaob_pkg::FULL16 - i_nb;
        n_bc[0] = i_side.color.base_red;
        n_bc[1] = i_side.color.base_green;
        n_bc[2] = i_side.color.base_blue;
        n_oc[0] = i_side.color.over_red;
        n_oc[1] = i_side.color.over_green;
        n_oc[2] = i_side.color.over_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    // products of each channel with its weight
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 3; k++) begin
                r_pb[k] <= PW'(n_bc[k]) * PW'(i_nb);
                r_po[k] <= PW'(n_oc[k]) * PW'(n_no);
            end
            r_zero  <= i_side.zero;
            r_alpha <= i_side.alpha;
        end
    end

    // rounded weighted sums
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = r_pb[k] + r_po[k] + rgbaob_pkg::HALF16;
            n_ch[k]  = r_zero ? 8'h00 : n_sum[k][23:16];
        end
    end

    assign o_valid            = r_valid;
    assign o_result.out_red   = n_ch[0];
    assign o_result.out_green = n_ch[1];
    assign o_result.out_blue  = n_ch[2];
    assign o_result.out_alpha = r_alpha;

endmodule

### src/rgba8_alpha_over_blend.sv
// ----------------------------------------------------------------------------
// rgba8_alpha_over_blend : straight-alpha RGBA8 over compositor
// blends an overlay pixel onto a base pixel; while not stalled, one pixel pair per clock
// ----------------------------------------------------------------------------
// channel   dir  width  content
// s_axis    in   64     base r,g,b,a then overlay r,g,b,a (low bits first)
// m_axis    out  32     blended r,g,b then combined alpha (low bits first)
//
// one transaction per clock while the skid register is free; from accept to
// o_m_axis_tvalid the path is 2 weight stages, 16 divider cells, 1 product stage,
// 1 output register. the chain of 16 division cells sets the latency.
// i_rst_n is synchronous, active low, and clears all valid flags.
// a stalled output parks one result in a skid register; o_s_axis_tready
// drops only while that register is full, and the whole chain holds.
// ----------------------------------------------------------------------------
module rgba8_alpha_over_blend (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // base_red, base_green, base_blue, base_alpha,
    // over_red, over_green, over_blue, over_alpha
    input  logic [63:0] i_s_axis_tdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0] o_m_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready
);

    localparam int unsigned NCELL = rgbaob_pkg::DIV_STEPS;

    logic                  w_ce;
    rgbaob_pkg::t_pixel    w_pix;
    logic                  w_valid [NCELL+1];
    rgbaob_pkg::t_div      w_div   [NCELL+1];
    rgbaob_pkg::t_side     w_side  [NCELL+1];
    logic                  w_mix_valid;
    rgbaob_pkg::t_result   w_mix_result;

    logic                  r_out_valid;
    rgbaob_pkg::t_result   r_out_data;
    logic                  r_skid_valid;
    rgbaob_pkg::t_result   r_skid_data;
    logic                  n_out_valid;
    rgbaob_pkg::t_result   n_out_data;
    logic                  n_skid_valid;
    rgbaob_pkg::t_result   n_skid_data;
    logic                  n_arrive;

    // whole chain advances while the skid register is free
    assign w_ce            = !r_skid_valid;
    assign o_s_axis_tready = w_ce;
    assign w_pix           = rgbaob_pkg::t_pixel'(i_s_axis_tdata);

    // weights, dividend and alpha
    rgbaob_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (i_s_axis_tvalid),
        .i_pix   (w_pix),
        .o_valid (w_valid[0]),
        .o_div   (w_div[0]),
        .o_side  (w_side[0])
    );

    // chain of division cells, one quotient bit each
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        rgbaob_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_valid (w_valid[g]),
            .i_div   (w_div[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_div   (w_div[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    // colour weighting with the finished quotient
    rgbaob_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (w_ce),
        .i_valid  (w_valid[NCELL]),
        .i_nb     (w_div[NCELL].shift),
        .i_side   (w_side[NCELL]),
        .o_valid  (w_mix_valid),
        .o_result (w_mix_result)
    );

    // output register with one skid entry
    always_comb begin
        n_arrive     = w_mix_valid && w_ce;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (i_m_axis_tready) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (n_arrive) begin
            if (!r_out_valid || i_m_axis_tready) begin
                n_out_valid = 1'b1;
                n_out_data  = w_mix_result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = w_mix_result;
            end
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

### src/rgbaob_checker.sv
// ----------------------------------------------------------------------------
// rgbaob_checker : port-level checks for the compositor
// watches the stream ports only and is bound to the top level
// ----------------------------------------------------------------------------
`include "rgba8_alpha_over_blend_defines.svh"

module rgbaob_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_s_axis_tdata,
    input  logic        i_s_axis_tvalid,
    input  logic        o_s_axis_tready,
    input  logic [31:0] o_m_axis_tdata,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready
);

    // a stalled result transaction keeps its data
    `RGBAOB_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled output changed")

    // input backpressure only while a result is waiting
    `RGBAOB_ASSERT(a_bp_has_out, i_clk, i_rst_n, !o_s_axis_tready |-> o_m_axis_tvalid, "input stalled with no pending output")

    // ready drops only after an output stall
    `RGBAOB_ASSERT(a_bp_cause, i_clk, i_rst_n, $fell(o_s_axis_tready) |-> $past(o_m_axis_tvalid && !i_m_axis_tready), "ready fell without output stall")

    // reset empties the output and frees the input
    `RGBAOB_ASSERT_ANY(a_reset_state, i_clk, !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready, "bad state after reset")

endmodule

bind rgba8_alpha_over_blend rgbaob_checker u_rgbaob_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);

### dv/rgba8_over_checker.sv
// ----------------------------------------------------------------------------
// rgba8_over_checker : scoreboard for the rgba8 over compositor
// watches both stream channels and works out each blended pixel from the
// accepted input. checks every output transaction field by field, in order,
// and hands the failure count and the number of outstanding pixels to the
// testbench top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgba8_over_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // base_red, base_green, base_blue, base_alpha,
    // over_red, over_green, over_blue, over_alpha
    input  logic [63:0] i_s_tdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // out_red, out_green, out_blue, out_alpha
    input  logic [31:0] i_m_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    output int          o_fail_count,
    output int          o_pending
);

    rgbaob_pkg::t_result blended_q[$];

    // one colour channel weighted by the 16-bit base and overlay weights
    function automatic logic [7:0] mix_channel(input logic [7:0] b, input logic [7:0] o,
                                               input logic [31:0] nb,
                                               input logic [31:0] no);
        logic [31:0] acc;
        acc = 32'(b) * nb + 32'(o) * no + 32'h8000;
        return acc[23:16];
    endfunction

    // straight-alpha over of one pixel pair
    function automatic rgbaob_pkg::t_result blend_over(input rgbaob_pkg::t_pixel px);
        logic [31:0] wb;
        logic [31:0] wo;
        logic [31:0] sum;
        logic [47:0] nb_wide;
        logic [31:0] nb;
        logic [31:0] no;
        logic [31:0] cov;
        rgbaob_pkg::t_result res;
        wb  = (32'd255 - 32'(px.over_alpha)) * 32'(px.base_alpha);
        wo  = 32'(px.over_alpha) * 32'd255;
        sum = wb + wo;
        res = '0;
        // both weights zero leaves the colour black
        if (sum != 0) begin
            nb_wide = (48'(wb) * 48'd65535 + 48'(sum >> 1)) / 48'(sum);
            nb      = nb_wide[31:0];
            no      = 32'd65535 - nb;
            res.out_red   = mix_channel(px.base_red, px.over_red, nb, no);
            res.out_green = mix_channel(px.base_green, px.over_green, nb, no);
            res.out_blue  = mix_channel(px.base_blue, px.over_blue, nb, no);
        end
        cov = 32'(px.base_alpha)
            + (32'(px.over_alpha) * (32'd255 - 32'(px.base_alpha)) + 32'd128) / 32'd255;
        res.out_alpha = cov[7:0];
        return res;
    endfunction

    // predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        rgbaob_pkg::t_result exp_px;
        rgbaob_pkg::t_result got_px;
        if (!i_rst_n) begin
            blended_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                blended_q.push_back(blend_over(rgbaob_pkg::t_pixel'(i_s_tdata)));
            end
            if (i_m_tvalid && i_m_tready) begin
                got_px = rgbaob_pkg::t_result'(i_m_tdata);
                if (blended_q.size() == 0) begin
                    $display("%0t: unexpected output pixel, expected none actual %h",
                             $time, got_px);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_px = blended_q.pop_front();
                    if (got_px.out_red !== exp_px.out_red)
                        $display("%0t: out_red expected %0d actual %0d",
                                 $time, exp_px.out_red, got_px.out_red);
                    if (got_px.out_green !== exp_px.out_green)
                        $display("%0t: out_green expected %0d actual %0d",
                                 $time, exp_px.out_green, got_px.out_green);
                    if (got_px.out_blue !== exp_px.out_blue)
                        $display("%0t: out_blue expected %0d actual %0d",
                                 $time, exp_px.out_blue, got_px.out_blue);
                    if (got_px.out_alpha !== exp_px.out_alpha)
                        $display("%0t: out_alpha expected %0d actual %0d",
                                 $time, exp_px.out_alpha, got_px.out_alpha);
                    if (got_px !== exp_px)
                        o_fail_count <= o_fail_count + 1;
                end
            end
            o_pending <= blended_q.size();
        end
    end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench : top level for the rgba8 over compositor
// drives directed corner pixels then random pixel pairs with random idle
// cycles on both channels, a long receiver hold-off to back up the pipeline,
// and gives the verdict from the checker's failure count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_PIXELS  = 1300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic [63:0] s_tdata          = '0;
    logic        s_tvalid         = 1'b0;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready         = 1'b0;
    int          fail_count;
    int          pending;
    int          rx_cycle         = 0;

    rgba8_alpha_over_blend u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready)
    );

    rgba8_over_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (s_tdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // pixel pair from its eight channels
    function automatic rgbaob_pkg::t_pixel pixel_pair(input logic [7:0] br,
                                                      input logic [7:0] bg,
                                                      input logic [7:0] bb,
                                                      input logic [7:0] ba,
                                                      input logic [7:0] orr,
                                                      input logic [7:0] og,
                                                      input logic [7:0] ob,
                                                      input logic [7:0] oa);
        rgbaob_pkg::t_pixel px;
        px.base_red   = br;
        px.base_green = bg;
        px.base_blue  = bb;
        px.base_alpha = ba;
        px.over_red   = orr;
        px.over_green = og;
        px.over_blue  = ob;
        px.over_alpha = oa;
        return px;
    endfunction

    // alpha biased toward the edges of its range
    function automatic logic [7:0] edgy_alpha();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd127;
            3:       return 8'd128;
            4:       return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // colour channel, mostly random with some extremes
    function automatic logic [7:0] rand_colour();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        return 8'($urandom);
    endfunction

    // offer one pixel pair and hold it until the transaction completes
    task automatic send_pixel(input rgbaob_pkg::t_pixel px, input bit may_idle);
        int gap;
        s_tdata  <= px;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        if (may_idle && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 2);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // receiver: random idling, one long hold-off, one stretch always ready
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_cycle >= 300 && rx_cycle < 460)
                m_tready <= 1'b0;
            else if (rx_cycle >= 1200 && rx_cycle < 1700)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 30);
            rx_cycle <= rx_cycle + 1;
            @(posedge i_clk);
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet = quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // reset, stimulus and verdict
    initial begin
        rgbaob_pkg::t_pixel px;
        logic [7:0] ba;
        logic [7:0] oa;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_pixel(pixel_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1);
        send_pixel(pixel_pair(8'd255, 8'd255, 8'd255, 8'd255,
                              8'd255, 8'd255, 8'd255, 8'd255), 1'b1);
        // both weights zero, colours must go black
        send_pixel(pixel_pair(8'd255, 8'd255, 8'd255, 8'd0,
                              8'd255, 8'd255, 8'd255, 8'd0), 1'b1);
        send_pixel(pixel_pair(8'd12, 8'd200, 8'd99, 8'd0, 8'd240, 8'd7, 8'd150, 8'd0), 1'b1);
        // opaque base with transparent overlay
        send_pixel(pixel_pair(8'd10, 8'd20, 8'd30, 8'd255, 8'd200, 8'd210, 8'd220, 8'd0), 1'b1);
        // opaque overlay
        send_pixel(pixel_pair(8'd10, 8'd20, 8'd30, 8'd255,
                              8'd200, 8'd210, 8'd220, 8'd255), 1'b1);
        send_pixel(pixel_pair(8'd10, 8'd20, 8'd30, 8'd0, 8'd200, 8'd210, 8'd220, 8'd255), 1'b1);
        // barely visible coverage
        send_pixel(pixel_pair(8'd255, 8'd0, 8'd128, 8'd0, 8'd0, 8'd255, 8'd127, 8'd1), 1'b1);
        send_pixel(pixel_pair(8'd255, 8'd0, 8'd128, 8'd1, 8'd0, 8'd255, 8'd127, 8'd0), 1'b1);
        send_pixel(pixel_pair(8'd255, 8'd0, 8'd128, 8'd1, 8'd0, 8'd255, 8'd127, 8'd1), 1'b1);
        send_pixel(pixel_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd1), 1'b1);
        // half coverage both sides
        send_pixel(pixel_pair(8'd255, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd0, 8'd128), 1'b1);
        send_pixel(pixel_pair(8'd1, 8'd254, 8'd127, 8'd254, 8'd254, 8'd1, 8'd128, 8'd254), 1'b1);
        send_pixel(pixel_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd127), 1'b1);
        send_pixel(pixel_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd127), 1'b1);
        send_pixel(pixel_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA), 1'b1);
        send_pixel(pixel_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55), 1'b1);
        send_pixel(pixel_pair(8'd0, 8'd0, 8'd0, 8'd127, 8'd255, 8'd255, 8'd255, 8'd254), 1'b1);

        // random pixel pairs, a stretch in the middle offered back to back
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            if ($urandom_range(0, 99) < 60) begin
                ba = 8'($urandom);
                oa = 8'($urandom);
            end else begin
                ba = edgy_alpha();
                oa = edgy_alpha();
            end
            px = pixel_pair(rand_colour(), rand_colour(), rand_colour(), ba,
                            rand_colour(), rand_colour(), rand_colour(), oa);
            send_pixel(px, !(n >= 600 && n < 900));
        end
        s_tvalid <= 1'b0;

        // drain the pipeline, then look for stray outputs
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/rgbaob_pkg.sv
src/rgbaob_prep.sv
src/rgbaob_div_cell.sv
src/rgbaob_mix.sv
src/rgba8_alpha_over_blend.sv
src/rgbaob_checker.sv
dv/rgba8_over_checker.sv
dv/testbench.sv
